// ===== rtl/line_plane_intersection_defines.svh =====
// ----------------------------------------------------------------------------
// line_plane_intersection_defines
// Assertion macros shared by the checker of the plane clipping block.
// ----------------------------------------------------------------------------
`ifndef LINE_PLANE_INTERSECTION_DEFINES_SVH
`define LINE_PLANE_INTERSECTION_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define LPI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define LPI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lpi_pkg.sv =====
// ----------------------------------------------------------------------------
// lpi_pkg
// Types and constants shared by the plane clipping modules.
// ----------------------------------------------------------------------------
package lpi_pkg;

    // Queue between front and back
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QAW    = 3;

    // Quotient bits kept by the divider (t needs 32 plus one for the bound)
    localparam int unsigned QB = 33;
    // Product, sum and magnitude widths of the dot products
    localparam int unsigned PW = 65;
    localparam int unsigned SW = 67;
    localparam int unsigned DW = 66;

    // Result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_PAR = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_PX = 3'd0;
    localparam logic [2:0] REG_PY = 3'd1;
    localparam logic [2:0] REG_PZ = 3'd2;
    localparam logic [2:0] REG_NX = 3'd3;
    localparam logic [2:0] REG_NY = 3'd4;
    localparam logic [2:0] REG_NZ = 3'd5;

    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // Plane held in configuration
    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] n;
    } t_plane;

    // Classified segment carried from front to back
    typedef struct packed {
        logic [2:0][31:0] a;
        logic [2:0][32:0] d;
        logic             par;
        logic             neg;
    } t_seg;

    // Queue status
    typedef struct packed {
        logic [QAW:0] count;
        logic         empty;
    } t_q_stat;

endpackage

// ===== rtl/line_plane_intersection.sv =====
// ----------------------------------------------------------------------------
// line_plane_intersection: clips a 3D segment against a configured plane.
// Throughput one item per cycle while i_out_stall and o_in_stall are low:
// dot products, a 33-stage divider, products.
// Reset (synchronous, active low) empties all stages; plane resets to z-up.
// ----------------------------------------------------------------------------
module line_plane_intersection import lpi_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_start_x,
    input  logic [31:0] i_start_y,
    input  logic [31:0] i_start_z,
    input  logic [31:0] i_end_x,
    input  logic [31:0] i_end_y,
    input  logic [31:0] i_end_z,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hit_x,
    output logic [31:0] o_hit_y,
    output logic [31:0] o_hit_z,
    output logic [31:0] o_param_t,
    output logic [1:0]  o_status
);

    localparam int NW = SW + FRAC_BITS;
    localparam int QW = $bits(t_seg) + NW + DW;

    t_plane        r_plane;
    logic [1:0]    inflight;
    logic          f_valid;
    t_seg          f_seg, q_seg;
    logic [NW-1:0] f_num, q_num;
    logic [DW-1:0] f_den, q_den;
    logic [QAW:0]  occ;
    logic          pop;
    t_q_stat       q_stat;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.p <= '0;
            r_plane.n <= {32'h0001_0000, 32'h0, 32'h0};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PX:  r_plane.p[0] <= i_cfg_data;
                REG_PY:  r_plane.p[1] <= i_cfg_data;
                REG_PZ:  r_plane.p[2] <= i_cfg_data;
                REG_NX:  r_plane.n[0] <= i_cfg_data;
                REG_NY:  r_plane.n[1] <= i_cfg_data;
                REG_NZ:  r_plane.n[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Credit check: items in the front plus the queue never overrun it
    assign occ        = q_stat.count + (QAW+1)'(inflight);
    assign o_in_stall = occ >= (QAW+1)'(QDEPTH);

    lpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_plane    (r_plane),
        .i_valid    (i_in_valid && !o_in_stall),
        .i_a        ({i_start_z, i_start_y, i_start_x}),
        .i_b        ({i_end_z, i_end_y, i_end_x}),
        .o_inflight (inflight),
        .o_valid    (f_valid),
        .o_seg      (f_seg),
        .o_num      (f_num),
        .o_den      (f_den)
    );

    lpi_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_seg, f_num, f_den}),
        .i_pop   (pop),
        .o_data  ({q_seg, q_num, q_den}),
        .o_stat  (q_stat)
    );

    lpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_stat.empty),
        .i_seg       (q_seg),
        .i_num       (q_num),
        .i_den       (q_den),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_hit_x     (o_hit_x),
        .o_hit_y     (o_hit_y),
        .o_hit_z     (o_hit_z),
        .o_param_t   (o_param_t),
        .o_status    (o_status)
    );

endmodule

// ===== rtl/lpi_front.sv =====
// ----------------------------------------------------------------------------
// lpi_front
// Accepts segments, forms both dot products exactly and classifies them.
// ----------------------------------------------------------------------------
module lpi_front import lpi_pkg::*; #(
    parameter int FRAC_BITS = 16,
    localparam int NW = SW + FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_plane          i_plane,
    input  logic            i_valid,
    input  logic [2:0][31:0] i_a,
    input  logic [2:0][31:0] i_b,
    output logic [1:0]      o_inflight,
    output logic            o_valid,
    output t_seg            o_seg,
    output logic [NW-1:0]   o_num,
    output logic [DW-1:0]   o_den
);

    logic                 r_v1, r_v2, r_v3;
    logic [2:0][31:0]     r_a1, r_a2;
    logic signed [32:0]   r_pa1 [3];
    logic signed [32:0]   r_d1  [3];
    logic [2:0][32:0]     r_d2;
    logic signed [PW-1:0] r_pn2 [3];
    logic signed [PW-1:0] r_pd2 [3];
    t_seg                 r_seg3;
    logic [NW-1:0]        r_num3;
    logic [DW-1:0]        r_den3;

    logic signed [32:0]   n_pa [3];
    logic signed [32:0]   n_d  [3];
    logic signed [PW-1:0] n_pn [3];
    logic signed [PW-1:0] n_pd [3];
    logic signed [SW-1:0] num, den;
    logic [SW-1:0]        num_abs, den_abs;
    t_seg                 n_seg;

    // Differences p - a and b - a
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pa[i] = $signed({i_plane.p[i][31], i_plane.p[i]}) - $signed({i_a[i][31], i_a[i]});
            n_d[i]  = $signed({i_b[i][31], i_b[i]}) - $signed({i_a[i][31], i_a[i]});
        end
    end

    // Products with the normal
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pn[i] = $signed(i_plane.n[i]) * r_pa1[i];
            n_pd[i] = $signed(i_plane.n[i]) * r_d1[i];
        end
    end

    // Sums, signs and the rounded dividend
    always_comb begin
        num     = SW'(r_pn2[0]) + SW'(r_pn2[1]) + SW'(r_pn2[2]);
        den     = SW'(r_pd2[0]) + SW'(r_pd2[1]) + SW'(r_pd2[2]);
        num_abs = num[SW-1] ? SW'(-num) : SW'(num);
        den_abs = den[SW-1] ? SW'(-den) : SW'(den);
        n_seg.a   = r_a2;
        n_seg.d   = r_d2;
        n_seg.par = (den == '0);
        n_seg.neg = num[SW-1] ^ den[SW-1];
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        r_a1 <= i_a;
        r_a2 <= r_a1;
        for (int i = 0; i < 3; i++) begin
            r_pa1[i] <= n_pa[i];
            r_d1[i]  <= n_d[i];
            r_d2[i]  <= r_d1[i];
            r_pn2[i] <= n_pn[i];
            r_pd2[i] <= n_pd[i];
        end
        r_seg3 <= n_seg;
        r_num3 <= (NW'(num_abs[DW-1:0]) << FRAC_BITS) + NW'(den_abs[DW-1:1]);
        r_den3 <= den_abs[DW-1:0];
    end

    assign o_inflight = {1'b0, r_v1} + {1'b0, r_v2} + {1'b0, r_v3};
    assign o_valid    = r_v3;
    assign o_seg      = r_seg3;
    assign o_num      = r_num3;
    assign o_den      = r_den3;

endmodule

// ===== rtl/lpi_queue.sv =====
// ----------------------------------------------------------------------------
// lpi_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module lpi_queue import lpi_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_stat      o_stat
);

    logic [W-1:0]   r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_count;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== rtl/lpi_back.sv =====
// ----------------------------------------------------------------------------
// lpi_back
// Divides one quotient bit a stage, saturates t, forms the hit point.
// ----------------------------------------------------------------------------
module lpi_back import lpi_pkg::*; #(
    parameter int FRAC_BITS = 16,
    localparam int NW = SW + FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_seg          i_seg,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_valid,
    output logic [31:0]   o_hit_x,
    output logic [31:0]   o_hit_y,
    output logic [31:0]   o_hit_z,
    output logic [31:0]   o_param_t,
    output logic [1:0]    o_status
);

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic          en;

    // Divider stages
    logic          r_v   [QB+1];
    t_seg          r_seg [QB+1];
    logic          r_ovf [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [CW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];

    // t, product and output stages
    logic          r_vt, r_vm, r_vo;
    t_seg          r_segt, r_segm;
    logic [31:0]   r_t, r_tm, r_tmag;
    logic          r_tsat, r_tsatm;
    logic [63:0]   r_m [3];
    logic [2:0]    r_sgn;
    logic [31:0]   r_hit [3];
    logic [31:0]   r_to;
    logic [1:0]    r_st;

    logic [CW-1:0] num_ext;
    logic          n_tsat;
    logic [31:0]   n_t, n_tmag;
    logic [QB-1:0] qf;
    logic [63:0]   n_m [3];
    logic [2:0]    n_sgn;
    logic [31:0]   n_hit [3];
    logic [2:0]    hsat;
    logic [1:0]    n_st;

    // Whole back pipe moves unless the output item is held
    assign en    = !(r_vo && i_out_stall);
    assign o_pop = en && i_valid;

    assign num_ext = CW'(i_num);

    // Load stage: dividend, divisor and the out-of-range check
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_seg[0] <= i_seg;
            r_rem[0] <= num_ext;
            r_den[0] <= i_den;
            r_ovf[0] <= num_ext >= (CW'(i_den) << QB);
            r_q[0]   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (en)  r_v[0] <= i_valid;
    end

    // Restoring division, most significant quotient bit first
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int SH = QB - 1 - k;
        logic [CW-1:0] dsh;
        logic          ge;
        logic [QB-1:0] n_q;

        always_comb begin
            dsh     = CW'(r_den[k]) << SH;
            ge      = r_rem[k] >= dsh;
            n_q     = r_q[k];
            n_q[SH] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q[k+1]   <= n_q;
                r_seg[k+1] <= r_seg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else if (en)  r_v[k+1] <= r_v[k];
        end

        if (k < QB - 1) begin : g_fwd
            logic [CW-1:0] n_rem;
            assign n_rem = ge ? r_rem[k] - dsh : r_rem[k];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[k+1] <= n_rem;
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    // Sign and saturation of t
    always_comb begin
        qf = r_q[QB];
        if (r_seg[QB].neg) begin
            n_tsat = r_ovf[QB] || qf[32] || (qf[31] && (qf[30:0] != '0));
            n_t    = n_tsat ? S32_MIN : 32'(-qf[31:0]);
            n_tmag = n_tsat ? S32_MIN : qf[31:0];
        end else begin
            n_tsat = r_ovf[QB] || qf[32] || qf[31];
            n_t    = n_tsat ? S32_MAX : qf[31:0];
            n_tmag = n_tsat ? S32_MAX : qf[31:0];
        end
    end

    // Magnitude products |d| * |t|
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [32:0] dmag;
            dmag     = r_segt.d[i][32] ? 33'(-r_segt.d[i]) : r_segt.d[i];
            n_m[i]   = 64'(dmag) * 64'(r_tmag);
            n_sgn[i] = r_segt.d[i][32] ^ r_t[31];
        end
    end

    // Round, restore sign, add start, saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [63:0]        mr;
            logic signed [65:0] rv, sum;
            mr       = r_m[i] + (64'd1 << (FRAC_BITS - 1));
            rv       = $signed(66'(mr >> FRAC_BITS));
            sum      = $signed(66'($signed(r_segm.a[i]))) + (r_sgn[i] ? -rv : rv);
            hsat[i]  = (sum > $signed(66'($signed(S32_MAX))))
                    || (sum < $signed(66'($signed(S32_MIN))));
            if (sum > $signed(66'($signed(S32_MAX))))      n_hit[i] = S32_MAX;
            else if (sum < $signed(66'($signed(S32_MIN)))) n_hit[i] = S32_MIN;
            else                                            n_hit[i] = sum[31:0];
        end
        if (r_segm.par)                  n_st = ST_PAR;
        else if (r_tsatm || (hsat != '0)) n_st = ST_SAT;
        else                              n_st = ST_OK;
    end

    // Tail valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt <= 1'b0;
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_vt <= r_v[QB];
            r_vm <= r_vt;
            r_vo <= r_vm;
        end
    end

    // Tail payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_segt  <= r_seg[QB];
            r_t     <= n_t;
            r_tmag  <= n_tmag;
            r_tsat  <= n_tsat;
            r_segm  <= r_segt;
            r_tm    <= r_t;
            r_tsatm <= r_tsat;
            r_sgn   <= n_sgn;
            for (int i = 0; i < 3; i++) begin
                r_m[i]   <= n_m[i];
                r_hit[i] <= r_segm.par ? '0 : n_hit[i];
            end
            r_to <= r_segm.par ? '0 : r_tm;
            r_st <= n_st;
        end
    end

    assign o_valid   = r_vo;
    assign o_hit_x   = r_hit[0];
    assign o_hit_y   = r_hit[1];
    assign o_hit_z   = r_hit[2];
    assign o_param_t = r_to;
    assign o_status  = r_st;

endmodule

// ===== rtl/lpi_checker.sv =====
// ----------------------------------------------------------------------------
// lpi_checker
// Port-level checks of the plane clipping block, bound to its top level.
// ----------------------------------------------------------------------------
`include "line_plane_intersection_defines.svh"

module lpi_checker import lpi_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_hit_x,
    input logic [31:0] o_hit_y,
    input logic [31:0] o_hit_z,
    input logic [31:0] o_param_t,
    input logic [1:0]  o_status
);

    // Status carries only the three defined codes
    `LPI_ASSERT_IMP(a_status_code, o_out_valid, (o_status == ST_OK) || (o_status == ST_PAR) || (o_status == ST_SAT), "bad status code")

    // A parallel segment gives all-zero fields
    `LPI_ASSERT_IMP(a_par_zero, o_out_valid && (o_status == ST_PAR), (o_hit_x == '0) && (o_hit_y == '0) && (o_hit_z == '0) && (o_param_t == '0), "parallel item with nonzero fields")

    // A held result item stays valid, with t, hit x and status stable
    `LPI_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_param_t) && $stable(o_hit_x) && $stable(o_status), "held item changed")

endmodule

bind line_plane_intersection lpi_checker u_lpi_checker (.*);
